### hw/rtl/sgm_pkg.sv
`timescale 1ns / 1ps
package sgm_pkg;
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 12;
	localparam int CFG_DATA_BITS   = 12;
	localparam int FIELD_PIX_BITS  = 16;
	localparam int MAG_BITS        = 16;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;
endpackage

### hw/rtl/sgm_if.sv
`timescale 1ns / 1ps
interface sgm_pixel_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic signed [15:0] pixel;
	modport source(output valid, output operation, output pixel, input ready);
	modport sink(input valid, input operation, input pixel, output ready);
endinterface

interface sgm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] magnitude;
	logic        line_end;
	logic        frame_end;
	modport source(output valid, output magnitude, output line_end, output frame_end,
		input ready);
	modport sink(input valid, input magnitude, input line_end, input frame_end,
		output ready);
endinterface

### hw/rtl/sgm_ram.sv
`timescale 1ns / 1ps
module sgm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/sgm_isqrt.sv
`timescale 1ns / 1ps
module sgm_isqrt #(
	parameter int VW = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VW-1:0]         operand,
	output logic                  done,
	output logic [(VW+1)/2-1:0]   root
);
	localparam int RB   = (VW + 1) / 2;
	localparam int PW   = 2 * RB;
	localparam int CNTW = $clog2(RB + 1);

	logic [PW-1:0]   val_q;
	logic [RB-1:0]   rem_q;
	logic [RB-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RB+1:0]   rem_sh;
	logic [RB+1:0]   trial;
	logic [RB+1:0]   rem_next;
	logic            ge;

	// two operand bits enter the partial remainder per cycle
	assign rem_sh   = {rem_q, val_q[PW-1:PW-2]};
	assign trial    = {root_q, 2'b01};
	assign ge       = rem_sh >= trial;
	assign rem_next = ge ? rem_sh - trial : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= PW'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= rem_next[RB-1:0];
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

### hw/rtl/sobel_gradient_magnitude.sv
`timescale 1ns / 1ps
// channel  | dir | payload                                | transfer
// pixels   | in  | operation, pixel                       | valid & ready
// results  | out | magnitude, line_end, frame_end         | valid & ready
// cfg      | in  | cfg_index, cfg_data                    | cfg_we
// one item at a time: line store read and write-back, then per result the difference,
// square and sum stages, the serial square root and the load of the output register
// items causing no result end after the line store step; the line stores have one read port each
// reset clears counters, window and control; line stores need no clearing
// a waiting result does not block the next pixel transfer
module sobel_gradient_magnitude
	import sgm_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	sgm_pixel_if.sink                pixels,
	sgm_result_if.source             results
);
	localparam int PB   = PIXEL_BITS;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
	localparam int DW   = PB + 3;
	localparam int SW   = 2 * DW + 1;
	localparam int VW   = SW - 5;
	localparam int RB   = (VW + 1) / 2;
	localparam int CMPW = (RB > MAG_BITS) ? RB : MAG_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_DIFF, S_SQR, S_SUM, S_ROOT, S_LOAD
	} state_t;

	state_t state_q;
	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic [CW-1:0]              col_q;
	logic [HEIGHT_REG_BITS-1:0] row_q;
	logic                       flush_q;
	logic [PB-1:0]              pix_q;
	logic                       last_q;
	logic                       drain_q;
	logic                       sel_q;
	logic signed [PB-1:0]       win_q [3][3];
	logic signed [DW-1:0]       dx_s1, dy_s1;
	logic [2*DW-1:0]            sqx_s2, sqy_s2;
	logic [MAG_BITS-1:0]        mag_q;
	logic                       le_q, fe_q, ov_q;

	logic                       in_xfer, out_xfer;
	logic [WW-1:0]              w_ext, w_clamp;
	logic [CW-1:0]              wm1;
	logic [HEIGHT_REG_BITS-1:0] h_eff;
	logic [PB-1:0]              pix_raw;
	logic [PB-1:0]              up_rd, mid_rd;
	logic signed [PB-1:0]       top, mid, bot;
	logic                       ram_we, upper_we;
	logic                       skip;
	logic [1:0]                 il, ic;
	logic signed [DW-1:0]       dx_c, dy_c;
	logic signed [2*DW-1:0]     px_c, py_c;
	logic [SW-1:0]              sum_c;
	logic                       sq_start, sq_done;
	logic [RB-1:0]              root;
	logic [CMPW-1:0]            root_w;
	logic [MAG_BITS-1:0]        mag_c;
	logic                       load;

	assign in_xfer  = pixels.valid && pixels.ready;
	assign out_xfer = ov_q && results.ready;
	assign pixels.ready = (state_q == S_IDLE);

	always_comb begin
		w_ext = WW'(width_q);
		if (w_ext < WW'(2)) begin
			w_clamp = WW'(2);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = w_ext;
		end
		wm1   = CW'(w_clamp - WW'(1));
		h_eff = (height_q < HEIGHT_REG_BITS'(2)) ? HEIGHT_REG_BITS'(2) : height_q;
	end

	// low PIXEL_BITS of the field, zero beyond the field
	always_comb begin
		for (int i = 0; i < PB; i++) begin
			pix_raw[i] = (i < FIELD_PIX_BITS) ? pixels.pixel[i] : 1'b0;
		end
	end

	assign skip = (pixels.operation == OP_FLUSH) && (row_q == '0);

	sgm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(upper_we), .waddr(col_q), .wdata(mid),
		.raddr(col_q), .rdata(up_rd)
	);

	sgm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(ram_we), .waddr(col_q), .wdata(bot),
		.raddr(col_q), .rdata(mid_rd)
	);

	always_comb begin
		mid      = $signed(mid_rd);
		top      = (row_q >= HEIGHT_REG_BITS'(2)) ? $signed(up_rd) : mid;
		bot      = (flush_q || drain_q) ? mid : $signed(pix_q);
		ram_we   = (state_q == S_READ);
		upper_we = ram_we && (row_q != '0);
	end

	always_comb begin
		il   = sel_q ? 2'd1 : 2'd0;
		ic   = sel_q ? 2'd2 : 2'd1;
		dx_c = (DW'(win_q[0][2]) - DW'(win_q[0][il]))
			+ ((DW'(win_q[1][2]) - DW'(win_q[1][il])) <<< 1)
			+ (DW'(win_q[2][2]) - DW'(win_q[2][il]));
		dy_c = (DW'(win_q[0][il]) - DW'(win_q[2][il]))
			+ ((DW'(win_q[0][ic]) - DW'(win_q[2][ic])) <<< 1)
			+ (DW'(win_q[0][2]) - DW'(win_q[2][2]));
		px_c  = dx_s1 * dx_s1;
		py_c  = dy_s1 * dy_s1;
		sum_c = SW'(sqx_s2) + SW'(sqy_s2);
	end

	assign sq_start = (state_q == S_SUM);

	sgm_isqrt #(.VW(VW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.operand(sum_c[SW-1:5]), .done(sq_done), .root(root)
	);

	always_comb begin
		root_w = CMPW'(root);
		mag_c  = (root_w > CMPW'(17'h0FFFF)) ? {MAG_BITS{1'b1}} : root_w[MAG_BITS-1:0];
		load   = (state_q == S_LOAD) && (!ov_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_BITS'(1024);
			height_q <= HEIGHT_REG_BITS'(2);
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			sel_q   <= 1'b0;
			ov_q    <= 1'b0;
			flush_q <= 1'b0;
			last_q  <= 1'b0;
			drain_q <= 1'b0;
			pix_q   <= '0;
			dx_s1   <= '0;
			dy_s1   <= '0;
			sqx_s2  <= '0;
			sqy_s2  <= '0;
			mag_q   <= '0;
			le_q    <= 1'b0;
			fe_q    <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else begin
			if (out_xfer && !load) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && !skip) begin
						flush_q <= (pixels.operation == OP_FLUSH);
						pix_q   <= pix_raw;
						last_q  <= col_q >= wm1;
						drain_q <= row_q >= h_eff;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (col_q == '0) begin
						for (int k = 0; k < 3; k++) begin
							win_q[0][k] <= top;
							win_q[1][k] <= mid;
							win_q[2][k] <= bot;
						end
					end else begin
						for (int r = 0; r < 3; r++) begin
							win_q[r][0] <= win_q[r][1];
							win_q[r][1] <= win_q[r][2];
						end
						win_q[0][2] <= top;
						win_q[1][2] <= mid;
						win_q[2][2] <= bot;
					end
					if (last_q) begin
						col_q <= '0;
						row_q <= drain_q ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					sel_q <= 1'b0;
					if (row_q != '0 && col_q != '0) begin
						state_q <= S_DIFF;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIFF: begin
					dx_s1   <= dx_c;
					dy_s1   <= dy_c;
					state_q <= S_SQR;
				end
				S_SQR: begin
					sqx_s2  <= $unsigned(px_c);
					sqy_s2  <= $unsigned(py_c);
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_ROOT;
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (load) begin
						ov_q  <= 1'b1;
						mag_q <= mag_c;
						le_q  <= sel_q;
						fe_q  <= sel_q && drain_q;
						if (!sel_q && last_q) begin
							sel_q   <= 1'b1;
							state_q <= S_DIFF;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid     = ov_q;
	assign results.magnitude = mag_q;
	assign results.line_end  = le_q;
	assign results.frame_end = fe_q;

	a_fe_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_end |-> results.line_end)
		else $error("frame end without line end");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(ov_q && !results.ready))
		else $error("result register overwritten");
	a_write_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !in_xfer)
		else $error("line store write overlaps a pixel transfer");
	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_ROOT)
		else $error("square root finished outside its wait");
endmodule

### dv/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
module sobel_gradient_magnitude_tb;
	import sgm_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		op_t op;
		logic signed [15:0] px;
	} pixel_item_t;

	typedef struct {
		logic [15:0] mag;
		logic le;
		logic fe;
	} mag_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	sgm_pixel_if pix_if ();
	sgm_result_if res_if ();

	sobel_gradient_magnitude i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels(pix_if.sink),
		.results(res_if.source)
	);

	pixel_item_t pending_pixels[$];
	mag_item_t expected_mags[$];
	int errors = 0;
	int results_seen = 0;
	int pixels_sent = 0;
	int pixels_planned = 0;

	// predictor state
	logic [10:0] cfg_width = 11'd1024;
	logic [11:0] cfg_height = 12'd2;
	logic signed [15:0] upper_store[LINE_DEPTH];
	logic signed [15:0] middle_store[LINE_DEPTH];
	longint win[3][3];
	int col_pos = 0;
	int row_pos = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, t;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			t = res | (64'd1 << b);
			if (t * t <= v) res = t;
		end
		return res;
	endfunction

	function automatic mag_item_t grad_mag(input int l, input int m, input int r,
		input logic le, input logic fe);
		longint dx, dy;
		longint unsigned s, q;
		mag_item_t e;
		dx = (win[0][r] - win[0][l]) + 2 * (win[1][r] - win[1][l]) + (win[2][r] - win[2][l]);
		dy = (win[0][l] - win[2][l]) + 2 * (win[0][m] - win[2][m]) + (win[0][r] - win[2][r]);
		s = longint'(dx * dx) + longint'(dy * dy);
		q = root64(s >> 5);
		e.mag = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
		e.le = le;
		e.fe = fe;
		return e;
	endfunction

	task automatic predict_sobel(input pixel_item_t it);
		int w, h, c;
		bit last, flush;
		longint top, mid, bot;
		w = cfg_width;
		h = (cfg_height < 2) ? 2 : cfg_height;
		if (w < 2) w = 2;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
		last = (c >= w - 1);
		flush = (it.op == OP_FLUSH);
		if (flush && row_pos == 0) return;
		mid = middle_store[c];
		top = (row_pos >= 2) ? upper_store[c] : mid;
		bot = (flush || row_pos >= h) ? mid : longint'(it.px);
		if (row_pos == 0) begin
			middle_store[c] = it.px;
		end else begin
			upper_store[c] = mid[15:0];
			middle_store[c] = bot[15:0];
		end
		if (c == 0) begin
			for (int k = 0; k < 3; k++) begin
				win[0][k] = top;
				win[1][k] = mid;
				win[2][k] = bot;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = bot;
		end
		if (row_pos >= 1 && c >= 1) begin
			expected_mags.push_back(grad_mag(0, 1, 2, 1'b0, 1'b0));
			if (last) expected_mags.push_back(grad_mag(1, 2, 2, 1'b1, row_pos >= h));
		end
		if (last) begin
			col_pos = 0;
			row_pos = (row_pos >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// driver
	int src_gap = 0;
	bit src_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		pixel_item_t it;
		bit fire, nv;
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			pix_if.operation <= OP_PIXEL;
			pix_if.pixel <= '0;
		end else begin
			fire = pix_if.valid && pix_if.ready;
			nv = pix_if.valid && !fire;
			if (fire) begin
				it.op = op_t'(pix_if.operation);
				it.px = pix_if.pixel;
				predict_sobel(it);
				pixels_sent++;
				if (pixels_sent % 97 == 0) src_burst = !src_burst;
				src_gap = src_burst ? 0 : $urandom_range(0, 17);
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pixels_sent == 1300 && expected_mags.size() != 0) begin
					// sender pause: let every result drain first
				end else if (pending_pixels.size() != 0) begin
					it = pending_pixels.pop_front();
					pix_if.operation <= it.op;
					pix_if.pixel <= it.px;
					nv = 1'b1;
				end
			end
			pix_if.valid <= nv;
		end
	end

	// monitor
	int snk_stall = 0;
	bit snk_burst = 0;
	bit long_hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		mag_item_t e;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (expected_mags.size() == 0) begin
					report($sformatf("unexpected result mag=%0d", res_if.magnitude));
				end else begin
					e = expected_mags.pop_front();
					if (res_if.magnitude !== e.mag)
						report($sformatf("magnitude %0d, want %0d", res_if.magnitude, e.mag));
					if (res_if.line_end !== e.le)
						report($sformatf("line_end %b, want %b", res_if.line_end, e.le));
					if (res_if.frame_end !== e.fe)
						report($sformatf("frame_end %b, want %b", res_if.frame_end, e.fe));
				end
				if (results_seen % 113 == 0) snk_burst = !snk_burst;
				snk_stall = snk_burst ? 0 : $urandom_range(0, 17);
				if (results_seen == 300 && !long_hold_done) begin
					long_hold_done = 1;
					snk_stall = 400;
				end
			end else if (snk_stall > 0) begin
				snk_stall--;
			end
			res_if.ready <= (snk_stall == 0);
		end
	end

	// watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sobel_gradient_magnitude verification failed");
			$finish;
		end
	end

	task automatic push_pixel(input op_t op, input logic signed [15:0] px);
		pixel_item_t it;
		it.op = op;
		it.px = px;
		pending_pixels.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || pix_if.valid || expected_mags.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [11:0] wval, input logic [11:0] hval);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= wval;
		cfg_width = wval[10:0];
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= hval;
		cfg_height = hval;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_pixel(input logic signed [15:0] prev);
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2: return prev + 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom_range(0, 255));
		endcase
	endfunction

	// one well-formed frame: rows of pixels with a few flushes inside, then the drain row
	task automatic push_frame(input int w, input int h);
		logic signed [15:0] p;
		p = 16'($urandom);
		if ($urandom_range(0, 4) == 0) push_pixel(OP_FLUSH, 16'($urandom));
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				p = rand_pixel(p);
				if (r > 0 && $urandom_range(0, 11) == 0) push_pixel(OP_FLUSH, p);
				else push_pixel(OP_PIXEL, p);
			end
		end
		for (int c = 0; c < w; c++)
			push_pixel($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, 16'($urandom));
		pixels_planned += (h + 1) * w;
	endtask

	initial begin
		int w, h;
		logic [11:0] wraw, hraw;
		logic signed [15:0] p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: alternating extremes, plus the flush cases
		write_regs(12'd4, 12'd3);
		push_pixel(OP_FLUSH, 16'sh1234);
		push_pixel(OP_PIXEL, 16'sh7FFF); push_pixel(OP_PIXEL, 16'sh8000);
		push_pixel(OP_PIXEL, 16'sh7FFF); push_pixel(OP_PIXEL, 16'sh8000);
		push_pixel(OP_PIXEL, 16'sh8000); push_pixel(OP_PIXEL, 16'sh7FFF);
		push_pixel(OP_PIXEL, 16'sh8000); push_pixel(OP_PIXEL, 16'sh7FFF);
		push_pixel(OP_PIXEL, 16'sh7FFF); push_pixel(OP_FLUSH, 16'sh0000);
		push_pixel(OP_PIXEL, 16'sh0000); push_pixel(OP_PIXEL, -16'sd1);
		push_pixel(OP_FLUSH, 16'sh0000); push_pixel(OP_PIXEL, 16'sh0005);
		push_pixel(OP_FLUSH, 16'sh0000); push_pixel(OP_FLUSH, 16'shFFFF);
		wait_idle();

		// widest row under a clamped width, then narrow the rest of the frame
		write_regs(12'hFFF, 12'd1);
		p = 16'($urandom);
		for (int c = 0; c < LINE_DEPTH; c++) begin
			p = rand_pixel(p);
			push_pixel(OP_PIXEL, p);
		end
		wait_idle();
		write_regs(12'd4, 12'd1);
		for (int c = 0; c < 8; c++) begin
			p = rand_pixel(p);
			push_pixel((c >= 4 && $urandom_range(0, 1) == 1) ? OP_FLUSH : OP_PIXEL, p);
		end
		wait_idle();

		// clamped width and height at the low end
		write_regs(12'd1, 12'd0);
		push_frame(2, 2);
		wait_idle();

		// tallest height, then a lower height mid-frame forces the drain
		write_regs(12'd0, 12'd4095);
		for (int c = 0; c < 10; c++) begin
			p = rand_pixel(p);
			push_pixel(OP_PIXEL, p);
		end
		wait_idle();
		write_regs(12'd2, 12'd3);
		push_pixel(OP_PIXEL, 16'($urandom));
		push_pixel(OP_FLUSH, 16'($urandom));
		wait_idle();

		pixels_planned = 0;
		while (pixels_planned < 600) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 12);
			h = $urandom_range(2, 10);
			wraw = 12'(w) | 12'($urandom_range(0, 1) << 11);
			hraw = 12'(h);
			write_regs(wraw, hraw);
			repeat ($urandom_range(1, 3)) push_frame(w, h);
			wait_idle();
		end

		if (expected_mags.size() != 0) report("results left over at end");
		if (errors == 0) begin
			$display("sobel_gradient_magnitude verification clean");
		end else begin
			$display("sobel_gradient_magnitude verification failed");
		end
		$finish;
	end
endmodule
